// ===== src/scan_report_field_filter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Scan report field filter assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SCAN_REPORT_FIELD_FILTER_TOP_DEFINES_SVH
`define SCAN_REPORT_FIELD_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define SRFF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("srff assertion failed");
// Condition must never be seen outside reset.
`define SRFF_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("srff forbidden condition seen");
`else
`define SRFF_ASSERT(lbl, clk, rstn, prop)
`define SRFF_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== src/srff_pkg.sv =====
// ----------------------------------------------------------------------------
// Scan report field filter package
// Shared types and constants of the filter, its queue and its top level.
// ----------------------------------------------------------------------------
package srff_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SSID_COMMA = 2'd0;
  localparam logic [1:0] REG_FIRST_FLD  = 2'd1;
  localparam logic [1:0] REG_SECOND_FLD = 2'd2;

  localparam logic [CFG_W-1:0] SSID_COMMA_RST = 4'd8;
  localparam logic [CFG_W-1:0] FIRST_FLD_RST  = 4'd0;
  localparam logic [CFG_W-1:0] SECOND_FLD_RST = 4'd2;

  typedef struct packed {
    logic [CFG_W-1:0] ssid_comma;
    logic [CFG_W-1:0] first_fld;
    logic [CFG_W-1:0] second_fld;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] data;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;   // results produced by this transaction, 0 to 2
    res_t       r0;
    res_t       r1;
  } step_out_t;

endpackage

// ===== src/srff_step.sv =====
// ----------------------------------------------------------------------------
// Scan report field filter step
// Parser state and per-byte decision; emits up to two result bytes.
// ----------------------------------------------------------------------------
`include "scan_report_field_filter_top_defines.svh"

module srff_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [srff_pkg::CHAR_W-1:0]  char_i,
  input  srff_pkg::cfg_t               cfg,
  output srff_pkg::step_out_t          res
);

  typedef enum logic [2:0] {
    PH_WAIT_D  = 3'd0,
    PH_SKIP    = 3'd1,
    PH_DIGITS  = 3'd2,
    PH_DROP    = 3'd3,
    PH_RECORDS = 3'd4
  } phase_t;

  phase_t                      phase_r,     phase_nxt;
  logic [1:0]                  digit_cnt_r, digit_cnt_nxt;
  logic [srff_pkg::CFG_W-1:0]  comma_cnt_r, comma_cnt_nxt;
  logic                        in_ssid_r,   in_ssid_nxt;

  logic [srff_pkg::CFG_W-1:0]  comma_inc;
  logic                        kept;

  assign comma_inc = comma_cnt_r + 4'd1;
  assign kept      = (comma_cnt_r == cfg.first_fld) || (comma_cnt_r == cfg.second_fld);

  always_comb begin
    phase_nxt     = phase_r;
    digit_cnt_nxt = digit_cnt_r;
    comma_cnt_nxt = comma_cnt_r;
    in_ssid_nxt   = in_ssid_r;
    res.num       = 2'd0;
    res.r0        = '{data: char_i, last: 1'b0};
    res.r1        = '{data: srff_pkg::CH_NL, last: 1'b0};

    if (char_i == srff_pkg::CH_NUL) begin
      // terminator: pass with last, back to header search
      phase_nxt     = PH_WAIT_D;
      digit_cnt_nxt = 2'd0;
      comma_cnt_nxt = '0;
      in_ssid_nxt   = 1'b0;
      res.num       = 2'd1;
      res.r0.last   = 1'b1;
    end else begin
      unique case (phase_r)
        PH_SKIP: begin
          phase_nxt     = PH_DIGITS;
          digit_cnt_nxt = 2'd0;
        end
        PH_DIGITS: begin
          if (char_i == srff_pkg::CH_NL) begin
            res.num       = 2'd1;
            phase_nxt     = PH_RECORDS;
            comma_cnt_nxt = '0;
            in_ssid_nxt   = 1'b0;
          end else begin
            res.num       = 2'd1;
            digit_cnt_nxt = digit_cnt_r + 2'd1;
            if (digit_cnt_nxt >= 2'd2) begin
              // second digit: close the count with a newline
              res.num   = 2'd2;
              phase_nxt = PH_DROP;
            end
          end
        end
        PH_DROP: begin
          if (char_i == srff_pkg::CH_NL) begin
            phase_nxt     = PH_RECORDS;
            comma_cnt_nxt = '0;
            in_ssid_nxt   = 1'b0;
          end
        end
        PH_RECORDS: begin
          priority if (char_i == srff_pkg::CH_NL) begin
            comma_cnt_nxt = '0;
            in_ssid_nxt   = 1'b0;
            res.num       = 2'd1;
          end else if (in_ssid_r) begin
            res.num = 2'd1;
          end else if (char_i == srff_pkg::CH_COMMA && comma_cnt_r < cfg.ssid_comma) begin
            if (kept) begin
              res.num = 2'd1;
            end
            comma_cnt_nxt = comma_inc;
            if (comma_inc == cfg.ssid_comma) begin
              in_ssid_nxt = 1'b1;
            end
          end else if (kept) begin
            res.num = 2'd1;
          end else begin
            res.num = 2'd0;
          end
        end
        default: begin
          // header search; unused codes behave the same
          if (char_i == srff_pkg::CH_D) begin
            phase_nxt     = PH_SKIP;
            digit_cnt_nxt = 2'd0;
          end else begin
            phase_nxt = PH_WAIT_D;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT_D;
      digit_cnt_r <= 2'd0;
      comma_cnt_r <= '0;
      in_ssid_r   <= 1'b0;
    end else if (go) begin
      phase_r     <= phase_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      comma_cnt_r <= comma_cnt_nxt;
      in_ssid_r   <= in_ssid_nxt;
    end
  end

  `SRFF_ASSERT(a_ssid_in_records, clk, rst_n, in_ssid_r |-> (phase_r == PH_RECORDS))
  `SRFF_ASSERT(a_nul_single_last, clk, rst_n,
    (go && char_i == srff_pkg::CH_NUL) |=> (phase_r == PH_WAIT_D && !in_ssid_r))

endmodule

// ===== src/srff_outq.sv =====
// ----------------------------------------------------------------------------
// Scan report field filter output queue
// Four-entry result queue taking up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
`include "scan_report_field_filter_top_defines.svh"

module srff_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_en,
  input  srff_pkg::step_out_t           push,
  input  logic                          pop,
  output logic                          room2,
  output logic                          nonempty,
  output srff_pkg::res_t                head
);

  srff_pkg::res_t                       q_r [srff_pkg::Q_DEPTH];
  logic [srff_pkg::Q_PTR_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [srff_pkg::Q_CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [srff_pkg::Q_PTR_W-1:0]         wr_ptr1;
  logic [1:0]                           n_push;

  assign n_push   = push_en ? push.num : 2'd0;
  assign wr_ptr1  = wr_ptr_r + srff_pkg::Q_PTR_W'(1);
  assign room2    = cnt_r <= srff_pkg::Q_CNT_W'(srff_pkg::Q_DEPTH - 2);
  assign nonempty = cnt_r != '0;
  assign head     = q_r[rd_ptr_r];
  assign cnt_nxt  = cnt_r + srff_pkg::Q_CNT_W'(n_push) - srff_pkg::Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + srff_pkg::Q_PTR_W'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + srff_pkg::Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  `SRFF_ASSERT_NEVER(a_no_overflow, clk, rst_n, (n_push != 2'd0) && !room2)
  `SRFF_ASSERT(a_cnt_bound, clk, rst_n,
    cnt_r <= srff_pkg::Q_CNT_W'(srff_pkg::Q_DEPTH))

endmodule

// ===== src/scan_report_field_filter_top.sv =====
// ----------------------------------------------------------------------------
// Scan report field filter
// Byte-stream filter that trims a scan report to count, channel, RSSI, SSID.
// ----------------------------------------------------------------------------
// The block takes one report byte per cycle and keeps up with that rate
// indefinitely as long as the output side takes one byte per cycle: each byte
// passes through an input register, combinational parse logic, and a
// four-entry result queue, so a result is offered only once it has been
// written into the queue, after its byte was taken into the input register.
// One input byte yields zero, one or two result bytes (two only for
// the second count digit, which is followed by a newline); the queue absorbs
// that burst, and input is held off only while fewer than two queue entries
// are free. Registers (ssid_comma_number at 0x0, first_kept_field at 0x4,
// second_kept_field at 0x8, 4 bits each) take effect on the next byte; write
// them only while no transaction is in flight. A zero byte ends a report, is
// passed on with out_last set, and returns the parser to header search.
// ----------------------------------------------------------------------------
`include "scan_report_field_filter_top_defines.svh"

module scan_report_field_filter_top (
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_out,
  output logic        out_last,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  srff_pkg::cfg_t                    cfg_r;
  logic                              in_valid_r;
  logic [srff_pkg::CHAR_W-1:0]       in_char_r;
  logic                              go;
  logic                              room2;
  logic                              pop;
  logic                              cfg_wr;
  logic [1:0]                        reg_idx;
  srff_pkg::step_out_t               step_res;
  srff_pkg::res_t                    head;

  // --- register port -------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ssid_comma <= srff_pkg::SSID_COMMA_RST;
      cfg_r.first_fld  <= srff_pkg::FIRST_FLD_RST;
      cfg_r.second_fld <= srff_pkg::SECOND_FLD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        srff_pkg::REG_SSID_COMMA: cfg_r.ssid_comma <= pwdata[srff_pkg::CFG_W-1:0];
        srff_pkg::REG_FIRST_FLD:  cfg_r.first_fld  <= pwdata[srff_pkg::CFG_W-1:0];
        srff_pkg::REG_SECOND_FLD: cfg_r.second_fld <= pwdata[srff_pkg::CFG_W-1:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      srff_pkg::REG_SSID_COMMA: prdata = {28'd0, cfg_r.ssid_comma};
      srff_pkg::REG_FIRST_FLD:  prdata = {28'd0, cfg_r.first_fld};
      srff_pkg::REG_SECOND_FLD: prdata = {28'd0, cfg_r.second_fld};
      default:                  prdata = 32'd0;
    endcase
  end

  // --- input register ------------------------------------------------------
  // Advance the held byte whenever the queue can take two results; the
  // register then frees up in the same cycle, so a new transaction is taken.
  assign go       = in_valid_r && room2;
  assign in_stall = in_valid_r && !room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_char_in;
    end
  end

  // --- parser --------------------------------------------------------------
  srff_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .char_i (in_char_r),
    .cfg    (cfg_r),
    .res    (step_res)
  );

  // --- result queue --------------------------------------------------------
  assign pop = out_valid && !out_stall;

  srff_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (go),
    .push     (step_res),
    .pop      (pop),
    .room2    (room2),
    .nonempty (out_valid),
    .head     (head)
  );

  assign out_byte_out = head.data;
  assign out_last     = head.last;

endmodule
